// File: hdl/fvphd_pkg.sv
// ----------------------------------------------------------------------------
// fvphd_pkg
// Types, register indexes and reset constants shared by the fill valve
// peak-and-hold driver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fvphd_pkg;

  localparam int unsigned CfgAddrW     = 3;
  localparam int unsigned CfgDataW     = 20;
  localparam int unsigned InDataW      = 16;
  localparam int unsigned OutDataW     = 120;
  localparam int unsigned OptoTicksDef = 100;

  localparam logic [19:0] VolumeLimitRst  = 20'd1000;
  localparam logic [9:0]  PeakDutyRst     = 10'd1023;
  localparam logic [9:0]  HoldInitRst     = 10'd400;
  localparam logic [9:0]  HoldMaxRst      = 10'd800;
  localparam logic [9:0]  HoldStepRst     = 10'd20;
  localparam logic [15:0] PeakTimeRst     = 16'd200;
  localparam logic [15:0] NoFlowTimeRst   = 16'd2000;
  localparam logic [15:0] AdjustIntRst    = 16'd500;
  localparam logic [9:0]  DutyMax         = 10'd1023;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_VOLUME_LIMIT   = 3'd0,
    CFG_PEAK_DUTY      = 3'd1,
    CFG_HOLD_INIT      = 3'd2,
    CFG_HOLD_MAX       = 3'd3,
    CFG_HOLD_STEP      = 3'd4,
    CFG_PEAK_TIME      = 3'd5,
    CFG_NO_FLOW_TIME   = 3'd6,
    CFG_ADJUST_INT     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [19:0] volume_limit;
    logic [9:0]  peak_duty;
    logic [9:0]  hold_duty_initial;
    logic [9:0]  hold_duty_max;
    logic [9:0]  hold_duty_step;
    logic [15:0] peak_time;
    logic [15:0] no_flow_time;
    logic [15:0] adjust_interval;
  } cfg_t;

  typedef struct packed {
    logic       button_pressed;
    logic       flow_seen;
    logic [9:0] volume_added;
    logic       start_fill;
    logic       start_allowed;
    logic       paused;
  } item_t;

  typedef struct packed {
    logic [9:0]  drive_duty;
    logic        opto_out;
    logic        valve_is_open;
    logic        manual_active;
    logic        filling_active;
    logic        fill_done;
    logic        start_accepted;
    logic [31:0] fill_volume_now;
    logic [31:0] fills_completed;
    logic [39:0] volume_lifetime;
  } result_t;

endpackage

// File: hdl/fvphd_cfg.sv
// ----------------------------------------------------------------------------
// fvphd_cfg
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvphd_cfg
  import fvphd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_VOLUME_LIMIT: cfg_nxt.volume_limit      = cfg_wdata;
        CFG_PEAK_DUTY:    cfg_nxt.peak_duty         = cfg_wdata[9:0];
        CFG_HOLD_INIT:    cfg_nxt.hold_duty_initial = cfg_wdata[9:0];
        CFG_HOLD_MAX:     cfg_nxt.hold_duty_max     = cfg_wdata[9:0];
        CFG_HOLD_STEP:    cfg_nxt.hold_duty_step    = cfg_wdata[9:0];
        CFG_PEAK_TIME:    cfg_nxt.peak_time         = cfg_wdata[15:0];
        CFG_NO_FLOW_TIME: cfg_nxt.no_flow_time      = cfg_wdata[15:0];
        CFG_ADJUST_INT:   cfg_nxt.adjust_interval   = cfg_wdata[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.volume_limit      <= VolumeLimitRst;
      cfg_r.peak_duty         <= PeakDutyRst;
      cfg_r.hold_duty_initial <= HoldInitRst;
      cfg_r.hold_duty_max     <= HoldMaxRst;
      cfg_r.hold_duty_step    <= HoldStepRst;
      cfg_r.peak_time         <= PeakTimeRst;
      cfg_r.no_flow_time      <= NoFlowTimeRst;
      cfg_r.adjust_interval   <= AdjustIntRst;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/fvphd_core.sv
// ----------------------------------------------------------------------------
// fvphd_core
// Valve state registers and the single-pass update for one millisecond tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fvphd_core
  import fvphd_pkg::*;
#(
  parameter int unsigned OPTO_PULSE_TICKS = OptoTicksDef
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [31:0] now_r, fill_r, peak_start_r, last_adjust_r, last_flow_r, opto_start_r;
  logic [31:0] fill_count_r;
  logic [39:0] life_r;
  logic [9:0]  hold_r, coil_r;
  logic        relay_r, manual_r, filling_r, valve_r, peak_r, opto_r;

  logic [31:0] now_nxt, fill_nxt, peak_start_nxt, last_adjust_nxt, last_flow_nxt;
  logic [31:0] opto_start_nxt, fill_count_nxt;
  logic [39:0] life_nxt;
  logic [9:0]  hold_nxt, coil_nxt;
  logic        relay_nxt, manual_nxt, filling_nxt, valve_nxt, peak_nxt, opto_nxt;
  logic        done, accepted, at_limit;
  logic [32:0] vol_sum;
  logic [40:0] life_sum;
  logic [10:0] hold_sum;

  always_comb begin
    now_nxt         = now_r + 32'd1;
    last_flow_nxt   = item.flow_seen ? now_nxt : last_flow_r;
    fill_nxt        = fill_r;
    relay_nxt       = relay_r;
    manual_nxt      = manual_r;
    filling_nxt     = filling_r;
    valve_nxt       = valve_r;
    peak_nxt        = peak_r;
    peak_start_nxt  = peak_start_r;
    last_adjust_nxt = last_adjust_r;
    hold_nxt        = hold_r;
    coil_nxt        = coil_r;
    opto_nxt        = opto_r;
    opto_start_nxt  = opto_start_r;
    fill_count_nxt  = fill_count_r;
    life_nxt        = life_r;
    done            = 1'b0;
    life_sum        = '0;
    hold_sum        = '0;

    accepted = item.start_fill && item.start_allowed;
    if (accepted) begin
      fill_nxt    = '0;
      relay_nxt   = 1'b1;
      manual_nxt  = 1'b0;
      filling_nxt = 1'b1;
    end

    vol_sum  = {1'b0, fill_nxt} + {23'd0, item.volume_added};
    fill_nxt = vol_sum[32] ? '1 : vol_sum[31:0];
    at_limit = fill_nxt >= {12'd0, cfg.volume_limit};

    if (!filling_nxt && !item.paused) begin
      if (item.button_pressed) begin
        if (at_limit) begin
          relay_nxt = 1'b0;
        end else begin
          manual_nxt = 1'b1;
          relay_nxt  = 1'b1;
        end
      end else if (manual_nxt) begin
        manual_nxt = 1'b0;
        relay_nxt  = 1'b0;
      end
    end

    if (relay_nxt && at_limit) begin
      relay_nxt   = 1'b0;
      valve_nxt   = 1'b0;
      coil_nxt    = '0;
      peak_nxt    = 1'b0;
      filling_nxt = 1'b0;
      if (!manual_nxt) begin
        opto_nxt       = 1'b1;
        opto_start_nxt = now_nxt;
      end
      if (fill_count_r != '1) begin
        fill_count_nxt = fill_count_r + 32'd1;
      end
      life_sum = {1'b0, life_r} + {9'd0, fill_nxt};
      life_nxt = life_sum[40] ? '1 : life_sum[39:0];
      done     = 1'b1;
    end else begin
      if (relay_nxt && !valve_r) begin
        valve_nxt      = 1'b1;
        coil_nxt       = cfg.peak_duty;
        peak_start_nxt = now_nxt;
        peak_nxt       = 1'b1;
      end else if (!relay_nxt && valve_r) begin
        valve_nxt = 1'b0;
        coil_nxt  = '0;
        peak_nxt  = 1'b0;
      end

      if (valve_nxt) begin
        if (peak_nxt && ((now_nxt - peak_start_nxt) > {16'd0, cfg.peak_time})) begin
          coil_nxt = hold_r;
          peak_nxt = 1'b0;
        end
        if ((now_nxt - last_adjust_r) > {16'd0, cfg.adjust_interval}) begin
          last_adjust_nxt = now_nxt;
          if (((now_nxt - last_flow_nxt) > {16'd0, cfg.no_flow_time}) &&
              (hold_r < cfg.hold_duty_max)) begin
            hold_sum = {1'b0, hold_r} + {1'b0, cfg.hold_duty_step};
            hold_nxt = hold_sum[10] ? DutyMax : hold_sum[9:0];
            coil_nxt = hold_nxt;
          end
        end
      end

      if (opto_r && ((now_nxt - opto_start_r) >= 32'(OPTO_PULSE_TICKS))) begin
        opto_nxt = 1'b0;
      end
    end

    res.drive_duty      = coil_nxt;
    res.opto_out        = opto_nxt;
    res.valve_is_open   = valve_nxt;
    res.manual_active   = manual_nxt;
    res.filling_active  = filling_nxt;
    res.fill_done       = done;
    res.start_accepted  = accepted;
    res.fill_volume_now = fill_nxt;
    res.fills_completed = fill_count_nxt;
    res.volume_lifetime = life_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      fill_r        <= '0;
      peak_start_r  <= '0;
      last_adjust_r <= '0;
      last_flow_r   <= '0;
      opto_start_r  <= '0;
      fill_count_r  <= '0;
      life_r        <= '0;
      hold_r        <= HoldInitRst;
      coil_r        <= '0;
      relay_r       <= 1'b0;
      manual_r      <= 1'b0;
      filling_r     <= 1'b0;
      valve_r       <= 1'b0;
      peak_r        <= 1'b0;
      opto_r        <= 1'b0;
    end else if (step) begin
      now_r         <= now_nxt;
      fill_r        <= fill_nxt;
      peak_start_r  <= peak_start_nxt;
      last_adjust_r <= last_adjust_nxt;
      last_flow_r   <= last_flow_nxt;
      opto_start_r  <= opto_start_nxt;
      fill_count_r  <= fill_count_nxt;
      life_r        <= life_nxt;
      hold_r        <= hold_nxt;
      coil_r        <= coil_nxt;
      relay_r       <= relay_nxt;
      manual_r      <= manual_nxt;
      filling_r     <= filling_nxt;
      valve_r       <= valve_nxt;
      peak_r        <= peak_nxt;
      opto_r        <= opto_nxt;
    end
  end

endmodule

// File: hdl/fill_valve_peak_hold_driver.sv
// ----------------------------------------------------------------------------
// fill_valve_peak_hold_driver
// Peak-and-hold fill valve controller advanced by one word per millisecond.
// ----------------------------------------------------------------------------
// Each input word is one millisecond tick carrying the button level, the flow
// flag, the millilitres measured, the start request with its permission and
// the pause flag. For every accepted input word exactly one result word is
// produced: coil duty, opto pulse, valve, manual and filling flags, the done
// and start-accepted strobes, the running fill volume and the lifetime totals.
// An accepted word lands in an input register; once the output register is
// empty or being emptied, the single pass through the core updates the
// valve state and loads the output register, which raises out_tvalid until
// the result is taken.
// The input and output registers form a two-deep path, so one word per cycle
// flows through while the receiver keeps out_tready high.
// When the receiver stalls, the result holds in the output register, one more
// word waits in the input register, and then in_tready drops until space frees.
// Reset (rst_n low at a clock edge) clears all valve state, empties both
// registers and restores every configuration register to its default; the
// ratcheting hold duty restarts at the default initial hold duty.
// The user must write configuration only while no word is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fill_valve_peak_hold_driver
  import fvphd_pkg::*;
#(
  parameter int unsigned OPTO_PULSE_TICKS = OptoTicksDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input words.
  input  logic                in_tvalid,
  output logic                in_tready,
  // button_pressed[0], flow_seen[1], volume_added[11:2], start_fill[12],
  // start_allowed[13], paused[14], zero pad[15]
  input  logic [InDataW-1:0]  in_tdata,
  // Result words.
  output logic                out_tvalid,
  input  logic                out_tready,
  // drive_duty[9:0], opto_out[10], valve_is_open[11], manual_active[12],
  // filling_active[13], fill_done[14], start_accepted[15],
  // fill_volume_now[47:16], fills_completed[79:48], volume_lifetime[119:80]
  output logic [OutDataW-1:0] out_tdata,
  // Configuration writes.
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  cfg_t    cfg;
  item_t   item_r;
  result_t res;
  logic    in_vld_r, in_vld_nxt;
  logic    out_vld_r, out_vld_nxt;
  logic [OutDataW-1:0] out_data_r;
  logic    in_take, step;

  // The core advances only when a tick is staged and the output register
  // is empty or being emptied this cycle.
  assign step      = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || step;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_vld_nxt  = in_take ? 1'b1 : (step ? 1'b0 : in_vld_r);
    out_vld_nxt = step ? 1'b1 : ((out_vld_r && out_tready) ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.button_pressed <= in_tdata[0];
      item_r.flow_seen      <= in_tdata[1];
      item_r.volume_added   <= in_tdata[11:2];
      item_r.start_fill     <= in_tdata[12];
      item_r.start_allowed  <= in_tdata[13];
      item_r.paused         <= in_tdata[14];
    end
    if (step) begin
      out_data_r <= {res.volume_lifetime, res.fills_completed, res.fill_volume_now,
                     res.start_accepted, res.fill_done, res.filling_active,
                     res.manual_active, res.valve_is_open, res.opto_out,
                     res.drive_duty};
    end
  end

  fvphd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fvphd_core #(
    .OPTO_PULSE_TICKS (OPTO_PULSE_TICKS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// File: bench/fill_valve_tick_checker.sv
// ----------------------------------------------------------------------------
// fill_valve_tick_checker
// Watches the tick and result channels of the fill valve driver, keeps its own
// copy of the valve state and registers, and checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fill_valve_tick_checker
  import fvphd_pkg::*;
#(
  parameter int unsigned OPTO_TICKS = OptoTicksDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_wr_en,
  input  logic [CfgAddrW-1:0] cfg_addr,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  mismatches,
  output int                  outstanding,
  output int                  compared,
  output int                  limit_stops,
  output int                  hold_steps
);

  cfg_t        regs;
  logic [31:0] tick_ms, vol, peak_t0, adjust_t0, flow_t0, opto_t0, stop_count;
  logic [39:0] life_ml;
  logic [9:0]  hold, coil;
  logic        relay, manual, auto_fill, valve_on, in_peak, opto_on;
  result_t     expected_ticks[$];
  int          n_bad, n_cmp, n_stop, n_step;

  // Advances the valve state by one millisecond tick and returns the result
  // word that tick should produce.
  function automatic result_t valve_tick(input item_t t);
    result_t     r;
    logic [32:0] vsum;
    logic [40:0] lsum;
    logic [10:0] hsum;
    logic [31:0] since;
    r = '0;
    tick_ms = tick_ms + 32'd1;
    if (t.flow_seen) flow_t0 = tick_ms;

    if (t.start_fill && t.start_allowed) begin
      vol = '0;
      relay = 1'b1;
      manual = 1'b0;
      auto_fill = 1'b1;
      r.start_accepted = 1'b1;
    end

    vsum = {1'b0, vol} + {23'd0, t.volume_added};
    vol = vsum[32] ? 32'hFFFF_FFFF : vsum[31:0];

    if (!auto_fill && !t.paused) begin
      if (t.button_pressed) begin
        if (vol >= {12'd0, regs.volume_limit}) begin
          relay = 1'b0;
        end else begin
          manual = 1'b1;
          relay = 1'b1;
        end
      end else if (manual) begin
        manual = 1'b0;
        relay = 1'b0;
      end
    end

    if (relay && vol >= {12'd0, regs.volume_limit}) begin
      // The limit shuts the valve and ends the fill; no peak, hold or opto-timeout step runs on this tick.
      relay = 1'b0;
      valve_on = 1'b0;
      coil = '0;
      in_peak = 1'b0;
      auto_fill = 1'b0;
      if (!manual) begin
        opto_on = 1'b1;
        opto_t0 = tick_ms;
      end
      if (stop_count != 32'hFFFF_FFFF) stop_count = stop_count + 32'd1;
      lsum = {1'b0, life_ml} + {9'd0, vol};
      life_ml = lsum[40] ? 40'hFF_FFFF_FFFF : lsum[39:0];
      r.fill_done = 1'b1;
      n_stop++;
    end else begin
      if (relay && !valve_on) begin
        valve_on = 1'b1;
        coil = regs.peak_duty;
        peak_t0 = tick_ms;
        in_peak = 1'b1;
      end else if (!relay && valve_on) begin
        valve_on = 1'b0;
        coil = '0;
        in_peak = 1'b0;
      end

      if (valve_on) begin
        since = tick_ms - peak_t0;
        if (in_peak && since > {16'd0, regs.peak_time}) begin
          coil = hold;
          in_peak = 1'b0;
        end
        since = tick_ms - adjust_t0;
        if (since > {16'd0, regs.adjust_interval}) begin
          adjust_t0 = tick_ms;
          since = tick_ms - flow_t0;
          if (since > {16'd0, regs.no_flow_time} && hold < regs.hold_duty_max) begin
            // The ratchet may overshoot the ceiling once, but never past 1023.
            hsum = {1'b0, hold} + {1'b0, regs.hold_duty_step};
            hold = (hsum > {1'b0, DutyMax}) ? DutyMax : hsum[9:0];
            coil = hold;
            n_step++;
          end
        end
      end

      since = tick_ms - opto_t0;
      if (opto_on && since >= OPTO_TICKS) opto_on = 1'b0;
    end

    r.drive_duty      = coil;
    r.opto_out        = opto_on;
    r.valve_is_open   = valve_on;
    r.manual_active   = manual;
    r.filling_active  = auto_fill;
    r.fill_volume_now = vol;
    r.fills_completed = stop_count;
    r.volume_lifetime = life_ml;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [39:0] want,
                             input logic [39:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_bad++;
    end
  endtask

  always @(posedge clk) begin
    item_t   t;
    result_t got, want;
    if (!rst_n) begin
      regs = '{VolumeLimitRst, PeakDutyRst, HoldInitRst, HoldMaxRst, HoldStepRst,
               PeakTimeRst, NoFlowTimeRst, AdjustIntRst};
      tick_ms = '0; vol = '0; peak_t0 = '0; adjust_t0 = '0; flow_t0 = '0;
      opto_t0 = '0; stop_count = '0; life_ml = '0; coil = '0;
      hold = HoldInitRst;
      relay = 1'b0; manual = 1'b0; auto_fill = 1'b0;
      valve_on = 1'b0; in_peak = 1'b0; opto_on = 1'b0;
      expected_ticks.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_VOLUME_LIMIT: regs.volume_limit      = cfg_wdata[19:0];
          CFG_PEAK_DUTY:    regs.peak_duty         = cfg_wdata[9:0];
          CFG_HOLD_INIT:    regs.hold_duty_initial = cfg_wdata[9:0];
          CFG_HOLD_MAX:     regs.hold_duty_max     = cfg_wdata[9:0];
          CFG_HOLD_STEP:    regs.hold_duty_step    = cfg_wdata[9:0];
          CFG_PEAK_TIME:    regs.peak_time         = cfg_wdata[15:0];
          CFG_NO_FLOW_TIME: regs.no_flow_time      = cfg_wdata[15:0];
          CFG_ADJUST_INT:   regs.adjust_interval   = cfg_wdata[15:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        t.button_pressed = in_tdata[0];
        t.flow_seen      = in_tdata[1];
        t.volume_added   = in_tdata[11:2];
        t.start_fill     = in_tdata[12];
        t.start_allowed  = in_tdata[13];
        t.paused         = in_tdata[14];
        expected_ticks.push_back(valve_tick(t));
      end

      if (out_tvalid && out_tready) begin
        got.drive_duty      = out_tdata[9:0];
        got.opto_out        = out_tdata[10];
        got.valve_is_open   = out_tdata[11];
        got.manual_active   = out_tdata[12];
        got.filling_active  = out_tdata[13];
        got.fill_done       = out_tdata[14];
        got.start_accepted  = out_tdata[15];
        got.fill_volume_now = out_tdata[47:16];
        got.fills_completed = out_tdata[79:48];
        got.volume_lifetime = out_tdata[119:80];
        if (expected_ticks.size() == 0) begin
          $display("%0t: result word %h arrived with nothing expected", $time, out_tdata);
          n_bad++;
        end else begin
          want = expected_ticks.pop_front();
          n_cmp++;
          check_field("drive_duty", want.drive_duty, got.drive_duty);
          check_field("opto_out", want.opto_out, got.opto_out);
          check_field("valve_is_open", want.valve_is_open, got.valve_is_open);
          check_field("manual_active", want.manual_active, got.manual_active);
          check_field("filling_active", want.filling_active, got.filling_active);
          check_field("fill_done", want.fill_done, got.fill_done);
          check_field("start_accepted", want.start_accepted, got.start_accepted);
          check_field("fill_volume_now", want.fill_volume_now, got.fill_volume_now);
          check_field("fills_completed", want.fills_completed, got.fills_completed);
          check_field("volume_lifetime", want.volume_lifetime, got.volume_lifetime);
        end
      end
    end
    mismatches  <= n_bad;
    outstanding <= expected_ticks.size();
    compared    <= n_cmp;
    limit_stops <= n_stop;
    hold_steps  <= n_step;
  end

endmodule

// File: bench/tb_fill_valve_peak_hold_driver.sv
// ----------------------------------------------------------------------------
// tb_fill_valve_peak_hold_driver
// Stimulus and verdict for the fill valve peak-and-hold driver.
// ----------------------------------------------------------------------------
// A short directed run at the reset register values walks through the manual
// button, the limit stop in manual mode, refused and repeated starts and an
// all-fields-high tick. Seven register settings follow, each with a random mix
// of automatic fills, manual button holds and loose random ticks. The settings
// take every register to its extremes and push the ratcheting hold duty from
// no step at all, through a single overshoot of its ceiling, up to saturation.
// A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fill_valve_peak_hold_driver;
  import fvphd_pkg::*;

  // Cycles without any accepted word before the run is declared hung.
  localparam int StallLimit = 2000;
  // Random words per register setting.
  localparam int WordsPerSetting = 90;
  localparam int NumSettings = 7;

  typedef enum int {SEQ_FILL, SEQ_MANUAL, SEQ_NOISE} seq_kind_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int mismatches, outstanding, compared, limit_stops, hold_steps;

  int words_sent = 0;
  int burst_left = 0;
  int budget_left = 0;
  int quiet_cycles = 0;
  int sink_mode = 0;
  int sink_left = 0;
  int sink_tick = 0;

  item_t plan [18];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fill_valve_peak_hold_driver dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  fill_valve_tick_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared),
    .limit_stops (limit_stops),
    .hold_steps  (hold_steps)
  );

  // The receiver switches at random between stall patterns: always ready,
  // mostly ready, mostly stalled, and a fixed duty cycle. The always-ready
  // stretches give long runs with no stalls.
  always @(posedge clk) begin
    sink_tick <= sink_tick + 1;
    if (sink_left == 0) begin
      sink_mode <= $urandom_range(0, 3);
      sink_left <= $urandom_range(20, 200);
    end else begin
      sink_left <= sink_left - 1;
    end
    case (sink_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ((sink_tick % 7) < 4);
    endcase
  end

  // Watchdog: any accepted word on either channel restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Register settings, one per phase. Hold duty only ever climbs, so the
  // order matters: no step first, then an overshoot of a low ceiling, a
  // normal climb, a zero ceiling, saturation at 1023, then the long-time and
  // zero extremes.
  function automatic cfg_t setting(input int p);
    case (p)
      1: return '{20'd5000, 10'd900, 10'd0, 10'd1023, 10'd0,
                  16'd3, 16'd2, 16'd1};
      2: return '{20'd30000, 10'd700, 10'd1023, 10'd600, 10'd7,
                  16'd5, 16'd4, 16'd2};
      3: return '{20'd1500, 10'd800, 10'd400, 10'd1023, 10'd50,
                  16'd10, 16'd20, 16'd5};
      4: return '{20'd2500, 10'd1023, 10'd512, 10'd0, 10'd1023,
                  16'd0, 16'd0, 16'd0};
      5: return '{20'd4000, 10'd300, 10'd100, 10'd1023, 10'd1023,
                  16'd2, 16'd3, 16'd3};
      6: return '{20'd1000000, 10'd1023, 10'd400, 10'd800, 10'd20,
                  16'd65535, 16'd65535, 16'd65535};
      default: return '{20'd0, 10'd0, 10'd0, 10'd0, 10'd0,
                        16'd0, 16'd0, 16'd0};
    endcase
  endfunction

  // Drives one register write and leaves the write enable high, so that
  // back-to-back writes never lower and raise it within one time step.
  task automatic put_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_setting(input cfg_t s);
    put_reg(CFG_VOLUME_LIMIT, s.volume_limit);
    put_reg(CFG_PEAK_DUTY, {10'd0, s.peak_duty});
    put_reg(CFG_HOLD_INIT, {10'd0, s.hold_duty_initial});
    put_reg(CFG_HOLD_MAX, {10'd0, s.hold_duty_max});
    put_reg(CFG_HOLD_STEP, {10'd0, s.hold_duty_step});
    put_reg(CFG_PEAK_TIME, {4'd0, s.peak_time});
    put_reg(CFG_NO_FLOW_TIME, {4'd0, s.no_flow_time});
    put_reg(CFG_ADJUST_INT, {4'd0, s.adjust_interval});
    cfg_wr_en <= 1'b0;
  endtask

  // Sends one tick word. The sender works in bursts: when a burst runs out
  // it drops tvalid for a random gap, possibly none, and picks a new burst length. Now and
  // then a long gap-free burst keeps the block fed every cycle that in_tready is high.
  task automatic send_tick(input item_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, t.paused, t.start_allowed, t.start_fill,
                  t.volume_added, t.flow_seen, t.button_pressed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    budget_left--;
    words_sent++;
  endtask

  // An accepted start followed by a run of ticks. Each run picks small or
  // wide volume steps and a flow rate, so that some fills run long enough
  // with no flow for the hold duty to ratchet.
  task automatic fill_run();
    item_t       t;
    int          len, flow_pct;
    logic [9:0]  scale;
    t = '0;
    t.start_fill = 1'b1;
    t.start_allowed = 1'b1;
    t.flow_seen = 1'($urandom_range(0, 1));
    t.volume_added = 10'($urandom_range(0, 50));
    send_tick(t);
    len = $urandom_range(3, 40);
    scale = ($urandom_range(0, 1) == 0) ? 10'd60 : 10'd1000;
    flow_pct = $urandom_range(0, 2) * 50;
    while (len > 0 && budget_left > 0) begin
      t = '0;
      t.volume_added = 10'($urandom_range(0, scale));
      t.flow_seen = ($urandom_range(0, 99) < flow_pct);
      t.paused = ($urandom_range(0, 7) == 0);
      t.button_pressed = ($urandom_range(0, 7) == 0);
      t.start_fill = ($urandom_range(0, 15) == 0);
      t.start_allowed = 1'($urandom_range(0, 1));
      send_tick(t);
      len--;
    end
  endtask

  // The button held for a while, occasionally paused, then released.
  task automatic manual_run();
    item_t      t;
    int         len;
    logic [9:0] scale;
    len = $urandom_range(2, 30);
    scale = ($urandom_range(0, 4) == 0) ? 10'd1000 : 10'd200;
    while (len > 0 && budget_left > 0) begin
      t = '0;
      t.button_pressed = 1'b1;
      t.paused = ($urandom_range(0, 9) == 0);
      t.flow_seen = 1'($urandom_range(0, 1));
      t.volume_added = 10'($urandom_range(0, scale));
      send_tick(t);
      len--;
    end
    if (budget_left > 0) begin
      t = '0;
      send_tick(t);
    end
  endtask

  // A few ticks with every field random.
  task automatic noise_run();
    item_t t;
    int    len;
    len = $urandom_range(1, 4);
    while (len > 0 && budget_left > 0) begin
      t.button_pressed = 1'($urandom_range(0, 1));
      t.flow_seen = 1'($urandom_range(0, 1));
      t.volume_added = 10'($urandom_range(0, 1000));
      t.start_fill = 1'($urandom_range(0, 1));
      t.start_allowed = 1'($urandom_range(0, 1));
      t.paused = 1'($urandom_range(0, 1));
      send_tick(t);
      len--;
    end
  endtask

  // The sender holds off until every expected result word has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    seq_kind_t kind;
    int        pick;
    // Fields per entry: button, flow, volume, start, allowed, paused.
    plan = '{
      '{1'b0, 1'b0, 10'd0,    1'b0, 1'b0, 1'b0},  // idle tick
      '{1'b1, 1'b0, 10'd0,    1'b0, 1'b0, 1'b1},  // button while paused is ignored
      '{1'b1, 1'b1, 10'd100,  1'b0, 1'b0, 1'b0},  // manual mode opens the valve
      '{1'b1, 1'b0, 10'd0,    1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 10'd1000, 1'b0, 1'b0, 1'b0},  // limit in manual mode, no opto
      '{1'b1, 1'b1, 10'd0,    1'b0, 1'b0, 1'b0},  // still held at the limit
      '{1'b0, 1'b0, 10'd0,    1'b0, 1'b0, 1'b0},  // release clears manual mode
      '{1'b0, 1'b0, 10'd0,    1'b1, 1'b0, 1'b0},  // start refused
      '{1'b0, 1'b1, 10'd0,    1'b1, 1'b1, 1'b0},  // start accepted
      '{1'b0, 1'b0, 10'd511,  1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b0, 10'd0,    1'b0, 1'b0, 1'b1},  // button during a fill
      '{1'b0, 1'b0, 10'd0,    1'b1, 1'b1, 1'b0},  // start again clears the volume
      '{1'b0, 1'b0, 10'd999,  1'b0, 1'b0, 1'b0},
      '{1'b0, 1'b1, 10'd1,    1'b0, 1'b0, 1'b0},  // reaches the limit, opto fires
      '{1'b0, 1'b0, 10'd0,    1'b0, 1'b0, 1'b0},
      '{1'b1, 1'b1, 10'd1000, 1'b1, 1'b1, 1'b1},  // every field high
      '{1'b0, 1'b0, 10'd512,  1'b1, 1'b1, 1'b0},
      '{1'b0, 1'b0, 10'd0,    1'b0, 1'b0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks run at the register values reset leaves behind.
    budget_left = $size(plan);
    foreach (plan[i]) send_tick(plan[i]);
    drain();

    for (int p = 1; p <= NumSettings; p++) begin
      apply_setting(setting(p));
      budget_left = WordsPerSetting;
      while (budget_left > 0) begin
        pick = $urandom_range(0, 99);
        kind = (pick < 50) ? SEQ_FILL : (pick < 75) ? SEQ_MANUAL : SEQ_NOISE;
        case (kind)
          SEQ_FILL:   fill_run();
          SEQ_MANUAL: manual_run();
          default:    noise_run();
        endcase
      end
      drain();
    end

    // A result can be taken only once its word has passed the input and output
    // registers; the wait below gives time for that.
    repeat (8) @(posedge clk);

    $display("Sent %0d tick words over %0d register settings plus the reset values.",
             words_sent, NumSettings);
    $display("Compared %0d results; %0d limit stops and %0d hold duty steps predicted.",
             compared, limit_stops, hold_steps);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
